// ===== hw/rtl/opa_pkg.sv =====
// shared types, codes and constants of the object pool allocator
package opa_pkg;

    localparam int ID_W          = 8;
    localparam int NUM_IDS       = 256;
    localparam int CNT_OUT_W     = 9;
    localparam int POOL_SIZE_DEF = 256;

    typedef logic [ID_W-1:0] t_id;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_ACTIVE = 2'd2
    } t_status;

    typedef struct packed {
        t_op operation;
        t_id release_id;
    } t_req;

    typedef struct packed {
        t_id                  result_id;
        t_status              status;
        logic [CNT_OUT_W-1:0] active_count;
    } t_rsp;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ARD,
        S_MRD,
        S_SCAN,
        S_SWP,
        S_WB2,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/opa_req_if.sv =====
// request channel: valid, ready and one request word
interface opa_req_if;
    logic          valid;
    logic          ready;
    opa_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/opa_rsp_if.sv =====
// response channel: valid, ready and one response word
interface opa_rsp_if;
    logic          valid;
    logic          ready;
    opa_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/object_pool_allocator_core.sv =====
// Object pool allocator with swap-remove release. The first active_count slots of a slot
// memory hold the active ids. After reset an init pass over all POOL_SIZE slots writes
// slot i with id i (modulo 256) and accepts no word meanwhile. One word is in work at a
// time; a finished response sits in an output register while the next word is taken.
// Allocate needs one slot memory read before its response is registered. With POOL_SIZE
// up to 256 every id is unique, an id-to-slot map memory finds the slot and release does
// a map read, a read of the last active slot, and the two write-backs of the swap in
// S_SWP and S_WB2 on the single write port of each memory. With POOL_SIZE above 256 ids
// repeat, so release scans the slot memory one slot per cycle from slot 0. Allocate on a
// full pool and release of an inactive id report their status and change nothing.
module object_pool_allocator_core #(
    parameter int POOL_SIZE = opa_pkg::POOL_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    opa_req_if.sink   i_req,
    opa_rsp_if.source o_rsp
);

    localparam int ID_W      = opa_pkg::ID_W;
    localparam int NUM_IDS   = opa_pkg::NUM_IDS;
    localparam int CNT_OUT_W = opa_pkg::CNT_OUT_W;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam bit UNIQUE    = (POOL_SIZE <= NUM_IDS);

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_SIZE);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POOL_SIZE - 1);

    // memories
    logic [ID_W-1:0]  r_slot_mem [POOL_SIZE];
    logic [IDX_W-1:0] r_map_mem  [NUM_IDS];
    logic [ID_W-1:0]  r_slot_rdata;
    logic [IDX_W-1:0] r_map_rdata;

    logic             slot_we;
    logic [IDX_W-1:0] slot_waddr;
    logic [ID_W-1:0]  slot_wdata;
    logic [IDX_W-1:0] slot_raddr;
    logic             map_we;
    logic [ID_W-1:0]  map_waddr;
    logic [IDX_W-1:0] map_wdata;
    logic [ID_W-1:0]  map_raddr;

    // control and payload registers
    opa_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_init_idx, n_init_idx;
    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_scan_idx, n_scan_idx;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_last, n_last;
    logic [ID_W-1:0]  r_id, n_id;
    logic [ID_W-1:0]  r_res_id, n_res_id;
    opa_pkg::t_status r_status, n_status;
    opa_pkg::t_rsp    r_out, n_out;

    logic [CNT_W-1:0]       cnt_m1;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W+ID_W-1:0]  init_ext;
    logic [ID_W-1:0]        init_id;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
    logic                   id_in_pool;
    logic                   map_found;

    assign cnt_m1     = r_count - CNT_W'(1);
    assign last_idx   = cnt_m1[IDX_W-1:0];
    assign init_ext   = {{ID_W{1'b0}}, r_init_idx};
    assign init_id    = init_ext[ID_W-1:0];
    assign cnt_ext    = {{CNT_OUT_W{1'b0}}, r_count};
    assign id_in_pool = (32'(r_id) < 32'(POOL_SIZE));
    assign map_found  = id_in_pool && (CNT_W'(r_map_rdata) < r_count);

    assign i_req.ready = (r_state == opa_pkg::S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_rdata <= r_slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_waddr] <= map_wdata;
        end
        r_map_rdata <= r_map_mem[map_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= opa_pkg::S_INIT;
            r_count     <= '0;
            r_init_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_init_idx  <= n_init_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= n_scan_idx;
        r_pos      <= n_pos;
        r_last     <= n_last;
        r_id       <= n_id;
        r_res_id   <= n_res_id;
        r_status   <= n_status;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_init_idx  = r_init_idx;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_scan_idx  = r_scan_idx;
        n_pos       = r_pos;
        n_last      = r_last;
        n_id        = r_id;
        n_res_id    = r_res_id;
        n_status    = r_status;
        n_out       = r_out;

        slot_we    = 1'b0;
        slot_waddr = r_pos;
        slot_wdata = r_slot_rdata;
        slot_raddr = last_idx;
        map_we     = 1'b0;
        map_waddr  = r_id;
        map_wdata  = r_last;
        map_raddr  = r_id;

        case (r_state)
            opa_pkg::S_INIT: begin
                slot_we    = 1'b1;
                slot_waddr = r_init_idx;
                slot_wdata = init_id;
                map_we     = UNIQUE;
                map_waddr  = init_id;
                map_wdata  = r_init_idx;
                if (r_init_idx == IDX_LAST) begin
                    n_state = opa_pkg::S_IDLE;
                end else begin
                    n_init_idx = r_init_idx + IDX_W'(1);
                end
            end
            opa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_id = i_req.data.release_id;
                    if (i_req.data.operation == opa_pkg::OP_ALLOC) begin
                        if (r_count == CNT_FULL) begin
                            n_res_id = '0;
                            n_status = opa_pkg::ST_FULL;
                            n_state  = opa_pkg::S_DONE;
                        end else begin
                            slot_raddr = r_count[IDX_W-1:0];
                            n_state    = opa_pkg::S_ARD;
                        end
                    end else begin
                        n_res_id = i_req.data.release_id;
                        if (UNIQUE) begin
                            map_raddr = i_req.data.release_id;
                            n_state   = opa_pkg::S_MRD;
                        end else if (r_count == '0) begin
                            n_status = opa_pkg::ST_NOT_ACTIVE;
                            n_state  = opa_pkg::S_DONE;
                        end else begin
                            slot_raddr = '0;
                            n_scan_idx = '0;
                            n_state    = opa_pkg::S_SCAN;
                        end
                    end
                end
            end
            opa_pkg::S_ARD: begin
                n_res_id = r_slot_rdata;
                n_status = opa_pkg::ST_OK;
                n_count  = r_count + CNT_W'(1);
                n_state  = opa_pkg::S_DONE;
            end
            opa_pkg::S_MRD: begin
                // map holds the slot of every id below POOL_SIZE
                if (map_found) begin
                    n_pos      = r_map_rdata;
                    n_last     = last_idx;
                    slot_raddr = last_idx;
                    n_state    = opa_pkg::S_SWP;
                end else begin
                    n_status = opa_pkg::ST_NOT_ACTIVE;
                    n_state  = opa_pkg::S_DONE;
                end
            end
            opa_pkg::S_SCAN: begin
                // read data is the slot at r_scan_idx; next read issued each cycle
                if (r_slot_rdata == r_id) begin
                    n_pos      = r_scan_idx;
                    n_last     = last_idx;
                    slot_raddr = last_idx;
                    n_state    = opa_pkg::S_SWP;
                end else if (CNT_W'(r_scan_idx) == cnt_m1) begin
                    n_status = opa_pkg::ST_NOT_ACTIVE;
                    n_state  = opa_pkg::S_DONE;
                end else begin
                    n_scan_idx = r_scan_idx + IDX_W'(1);
                    slot_raddr = r_scan_idx + IDX_W'(1);
                end
            end
            opa_pkg::S_SWP: begin
                // last active id moves into the released slot
                slot_we    = 1'b1;
                slot_waddr = r_pos;
                slot_wdata = r_slot_rdata;
                map_we     = UNIQUE;
                map_waddr  = r_slot_rdata;
                map_wdata  = r_pos;
                n_state    = opa_pkg::S_WB2;
            end
            opa_pkg::S_WB2: begin
                slot_we    = 1'b1;
                slot_waddr = r_last;
                slot_wdata = r_id;
                map_we     = UNIQUE;
                map_waddr  = r_id;
                map_wdata  = r_last;
                n_count    = cnt_m1;
                n_status   = opa_pkg::ST_OK;
                n_state    = opa_pkg::S_DONE;
            end
            opa_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.result_id    = r_res_id;
                    n_out.status       = r_status;
                    n_out.active_count = cnt_ext[CNT_OUT_W-1:0];
                    n_out_valid        = 1'b1;
                    n_state            = opa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = opa_pkg::S_IDLE;
            end
        endcase
    end

endmodule
